### hdl/stps_pkg.sv
// Package with the payload types, bundle type and codes shared by the task selector modules.
package stps_pkg;

   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_CURRENT = 2'd1;
   localparam logic [1:0] OP_QUEUE   = 2'd2;

   localparam logic KIND_MARK   = 1'b0;
   localparam logic KIND_SELECT = 1'b1;

   localparam logic POLICY_SRTF = 1'b0;
   localparam logic POLICY_PRIO = 1'b1;

   localparam logic REG_POLICY     = 1'b0;
   localparam logic REG_TICK_LIMIT = 1'b1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [15:0] TICK_LIMIT_RESET = 16'd1024;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  task_index;
      logic        is_current;
      logic        ready_req;
      logic [15:0] remaining;
      logic [7:0]  priority_req;
      logic [15:0] arrival;
      logic [15:0] duration;
      logic        coin;
      logic [15:0] tick;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        found;
      logic [5:0]  task_index_res;
      logic [15:0] tick_res;
      logic        last_res;
   } rsp_type;

   typedef struct packed {
      logic        policy;
      logic [15:0] tick_limit;
   } cfg_type;

   typedef struct packed {
      logic        draw;
      logic        sel;
      logic        found;
      logic [5:0]  cand_task;
      logic [5:0]  prev_task;
      logic [5:0]  sel_task;
      logic [15:0] tick;
   } bundle_type;

endpackage

### hdl/stps_front.sv
// Front end: accepts items, compares each candidate with the running best and emits result bundles.
module stps_front #(
   parameter int TIME_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  stps_pkg::req_type   req_payload,
   input  stps_pkg::cfg_type   cfg,
   input  logic                queue_full,
   output logic                push,
   output stps_pkg::bundle_type push_data
);
   import stps_pkg::*;

   localparam int TW = (TIME_BITS < 16) ? TIME_BITS : 16;
   localparam logic [15:0] TIME_MASK = 16'((32'h1 << TW) - 32'h1);

   logic          has_best_ff, has_best_in;
   logic          best_cur_ff, best_cur_in;
   logic [5:0]    best_task_ff, best_task_in;
   logic [TW-1:0] best_rem_ff, best_rem_in;
   logic [7:0]    best_pri_ff, best_pri_in;
   logic [TW-1:0] best_arr_ff, best_arr_in;
   logic [TW-1:0] best_dur_ff, best_dur_in;

   logic          accept;
   logic [TW-1:0] rem_t, arr_t, dur_t;
   logic [15:0]   tick_t;
   logic          is_cur_op, is_queue_op;
   logic          better, equal, take, draw, new_has;
   logic [5:0]    new_task;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign rem_t  = req_payload.remaining[TW-1:0];
   assign arr_t  = req_payload.arrival[TW-1:0];
   assign dur_t  = req_payload.duration[TW-1:0];
   assign tick_t = req_payload.tick & TIME_MASK;

   always_comb begin
      is_cur_op   = (req_payload.operation == OP_CURRENT);
      is_queue_op = (req_payload.operation == OP_QUEUE) && req_payload.ready_req;
      if (cfg.policy == POLICY_SRTF) begin
         better = rem_t < best_rem_ff;
         equal  = rem_t == best_rem_ff;
      end else begin
         better = req_payload.priority_req > best_pri_ff;
         equal  = req_payload.priority_req == best_pri_ff;
      end
      take = 1'b0;
      draw = 1'b0;
      if (is_cur_op) begin
         take = 1'b1;
      end else if (is_queue_op) begin
         if (!has_best_ff || better) begin
            take = 1'b1;
         end else if (equal) begin
            if (req_payload.is_current) begin
               take = 1'b1;
            end else if (best_cur_ff) begin
               take = 1'b0;
            end else if (arr_t != best_arr_ff) begin
               take = arr_t < best_arr_ff;
            end else if (dur_t != best_dur_ff) begin
               take = dur_t < best_dur_ff;
            end else begin
               draw = tick_t < cfg.tick_limit;
               take = !req_payload.coin;
            end
         end
      end
      new_has  = has_best_ff || take;
      new_task = take ? req_payload.task_index : best_task_ff;
   end

   always_comb begin
      has_best_in  = has_best_ff;
      best_cur_in  = best_cur_ff;
      best_task_in = best_task_ff;
      best_rem_in  = best_rem_ff;
      best_pri_in  = best_pri_ff;
      best_arr_in  = best_arr_ff;
      best_dur_in  = best_dur_ff;
      if (accept) begin
         if (take) begin
            has_best_in  = 1'b1;
            best_cur_in  = is_cur_op ? 1'b1 : req_payload.is_current;
            best_task_in = req_payload.task_index;
            best_rem_in  = rem_t;
            best_pri_in  = req_payload.priority_req;
            best_arr_in  = arr_t;
            best_dur_in  = dur_t;
         end
         if (req_payload.last) begin
            has_best_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_best_ff <= 1'b0;
      end else begin
         has_best_ff <= has_best_in;
      end
      best_cur_ff  <= best_cur_in;
      best_task_ff <= best_task_in;
      best_rem_ff  <= best_rem_in;
      best_pri_ff  <= best_pri_in;
      best_arr_ff  <= best_arr_in;
      best_dur_ff  <= best_dur_in;
   end

   always_comb begin
      push                = accept && (draw || req_payload.last);
      push_data.draw      = draw;
      push_data.sel       = req_payload.last;
      push_data.found     = new_has;
      push_data.cand_task = req_payload.task_index;
      push_data.prev_task = best_task_ff;
      push_data.sel_task  = new_has ? new_task : 6'd0;
      push_data.tick      = tick_t;
   end

endmodule

### hdl/stps_queue.sv
// Short first-in first-out queue of result bundles between the front and back ends.
module stps_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stps_pkg::bundle_type push_data,
   input  logic                 pop,
   output stps_pkg::bundle_type head,
   output logic                 full,
   output logic                 empty
);
   import stps_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type    slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/stps_back.sv
// Back end: takes bundles from the queue and delivers their draw marks and selection one by one.
module stps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  stps_pkg::bundle_type head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stps_pkg::rsp_type    rsp_payload
);
   import stps_pkg::*;

   localparam logic [1:0] STEP_CAND = 2'd0;
   localparam logic [1:0] STEP_PREV = 2'd1;
   localparam logic [1:0] STEP_SEL  = 2'd2;

   logic       busy_ff, busy_in;
   bundle_type cur_ff, cur_in;
   logic [1:0] step_ff, step_in;
   logic       is_mark, last_now, done;

   always_comb begin
      is_mark = cur_ff.draw && (step_ff != STEP_SEL);
      if (cur_ff.draw) begin
         last_now = cur_ff.sel ? (step_ff == STEP_SEL) : (step_ff == STEP_PREV);
      end else begin
         last_now = 1'b1;
      end
      rsp_valid                  = busy_ff;
      rsp_payload.kind           = is_mark ? KIND_MARK : KIND_SELECT;
      rsp_payload.found          = is_mark ? 1'b0 : cur_ff.found;
      rsp_payload.tick_res       = cur_ff.tick;
      rsp_payload.last_res       = last_now;
      if (is_mark && step_ff == STEP_CAND) begin
         rsp_payload.task_index_res = cur_ff.cand_task;
      end else if (is_mark) begin
         rsp_payload.task_index_res = cur_ff.prev_task;
      end else begin
         rsp_payload.task_index_res = cur_ff.sel_task;
      end
   end

   assign done = busy_ff && !rsp_stall && last_now;
   assign pop  = !empty && (!busy_ff || done);

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      step_in = step_ff;
      if (pop) begin
         busy_in = 1'b1;
         cur_in  = head;
         step_in = head.draw ? STEP_CAND : STEP_SEL;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && !rsp_stall) begin
         step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_CAND;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      cur_ff <= cur_in;
   end

endmodule

### hdl/srtf_priority_task_selector.sv
// Top level of the task selector: register port, front end, bundle queue and back end.
//
// The selector takes one item per cycle while the queue is not full. Each item is compared
// with the running best combinationally by plain comparators in the front end, so a new
// item may follow in the very next cycle. Items that cause results place one bundle in a
// QUEUE_DEPTH-entry queue; the back end delivers one result per cycle from it while rsp_stall
// is low, so an item with a coin draw and the last flag yields two marks and a selection in
// turn, while input transfers go on until the queue fills. Items that cause no result never
// occupy the queue. Registers should be written only while no run is open.
module srtf_priority_task_selector #(
   parameter int TIME_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  stps_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output stps_pkg::rsp_type                    rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [stps_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [stps_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [stps_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import stps_pkg::*;

   logic        policy_ff, policy_in;
   logic [15:0] tick_limit_ff, tick_limit_in;
   logic        csr_write;
   cfg_type     cfg;
   logic        push, pop, full, empty;
   bundle_type  push_data, head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      policy_in     = policy_ff;
      tick_limit_in = tick_limit_ff;
      if (csr_write && paddr[2] == REG_POLICY) begin
         policy_in = pwdata[0];
      end
      if (csr_write && paddr[2] == REG_TICK_LIMIT) begin
         tick_limit_in = pwdata[15:0];
      end
      if (paddr[2] == REG_POLICY) begin
         prdata = {{(CSR_DATA_BITS - 1){1'b0}}, policy_ff};
      end else begin
         prdata = {{(CSR_DATA_BITS - 16){1'b0}}, tick_limit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= POLICY_SRTF;
         tick_limit_ff <= TICK_LIMIT_RESET;
      end else begin
         policy_ff     <= policy_in;
         tick_limit_ff <= tick_limit_in;
      end
   end

   assign cfg.policy     = policy_ff;
   assign cfg.tick_limit = tick_limit_ff;

   stps_front #(
      .TIME_BITS(TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .cfg        (cfg),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   stps_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   stps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
